// File: src/bec_pkg.sv
// Shared types, constants and helper functions for the backslash escape codec.
// No dependencies; used by bec_step and backslash_escape_codec.
`default_nettype none

package bec_pkg;

    // Character codes
    localparam logic [7:0] BSLASH  = 8'h5C;
    localparam logic [7:0] ZERO_CH = 8'h30;
    localparam logic [7:0] NUL_CH  = 8'h00;

    // Output length saturates here in encode mode
    localparam logic [16:0] COUNT_MAX = 17'd131070;

    // Direction register codes
    localparam logic DIR_ENCODE = 1'b0;
    localparam logic DIR_DECODE = 1'b1;

    // Configuration register indexes
    localparam logic CFG_DIRECTION = 1'b0;
    localparam logic CFG_OUT_LIMIT = 1'b1;

    typedef logic [7:0] byte_t;

    // Per-message codec state
    typedef struct packed {
        logic        held;
        logic        stopped;
        logic [16:0] count;
    } codec_state_t;

    // One result word
    typedef struct packed {
        byte_t       data;
        logic        valid;
        logic        run_last;
        logic        msg_end;
        logic [16:0] len;
    } result_t;

    // Everything one input word produces
    typedef struct packed {
        logic [1:0]   n;
        result_t      r0;
        result_t      r1;
        codec_state_t next;
    } step_t;

    // Outcome of one attempted decode emit
    typedef struct packed {
        codec_state_t s;
        logic         ok;
    } dec_t;

    function automatic logic [16:0] sat_inc(input logic [16:0] c);
        sat_inc = (c < COUNT_MAX) ? c + 17'd1 : c;
    endfunction

    // Decode emit with the output limit applied before and after the byte
    function automatic dec_t dec_emit(input codec_state_t s, input logic [15:0] lim);
        dec_t d;
        d.s  = s;
        d.ok = 1'b0;
        if (!s.stopped) begin
            if (s.count >= {1'b0, lim}) begin
                d.s.stopped = 1'b1;
            end
            else begin
                d.s.count = s.count + 17'd1;
                d.ok      = 1'b1;
                if (d.s.count >= {1'b0, lim}) begin
                    d.s.stopped = 1'b1;
                end
            end
        end
        dec_emit = d;
    endfunction

endpackage

`default_nettype wire

// File: src/bec_step.sv
// Combinational step of the codec: one input word plus state gives up to two
// result words and the next state. Depends on bec_pkg.
`default_nettype none

module bec_step (
    input  wire bec_pkg::codec_state_t st,
    input  wire bec_pkg::byte_t        b,
    input  wire                        last,
    input  wire                        dir,
    input  wire [15:0]                 lim,
    output bec_pkg::step_t             step
);
    import bec_pkg::*;

    codec_state_t s;
    dec_t         d;
    result_t      res [2];
    logic [1:0]   n;
    logic         do_fresh;
    logic         idx;
    logic [16:0]  c1;
    logic [16:0]  c2;

    always_comb
    begin
        s        = st;
        d        = '0;
        n        = 2'd0;
        do_fresh = 1'b0;
        res[0]   = '0;
        res[1]   = '0;
        c1       = sat_inc(st.count);
        c2       = sat_inc(c1);

        if (dir == DIR_ENCODE) begin
            // Encode: NUL and backslash expand to two words
            if (b == NUL_CH || b == BSLASH) begin
                res[0] = '{data: BSLASH, valid: 1'b1, run_last: 1'b0,
                           msg_end: 1'b0, len: c1};
                res[1] = '{data: (b == NUL_CH) ? ZERO_CH : BSLASH, valid: 1'b1,
                           run_last: 1'b0, msg_end: 1'b0, len: c2};
                s.count = c2;
                n = 2'd2;
            end
            else begin
                res[0] = '{data: b, valid: 1'b1, run_last: 1'b0,
                           msg_end: 1'b0, len: c1};
                s.count = c1;
                n = 2'd1;
            end
        end
        else if (!s.stopped) begin
            // Decode: resolve an open escape pair first
            if (s.held) begin
                s.held = 1'b0;
                if (b == ZERO_CH) begin
                    d = dec_emit(s, lim);
                end
                else begin
                    d = dec_emit(s, lim);
                    do_fresh = (b != BSLASH) && !d.s.stopped;
                end
                s = d.s;
                if (d.ok) begin
                    res[0] = '{data: (b == ZERO_CH) ? NUL_CH : BSLASH, valid: 1'b1,
                               run_last: 1'b0, msg_end: 1'b0, len: s.count};
                    n = 2'd1;
                end
            end
            else begin
                do_fresh = 1'b1;
            end

            // Byte outside an escape pair
            if (do_fresh) begin
                if (last || (b != BSLASH && b != NUL_CH)) begin
                    d = dec_emit(s, lim);
                    s = d.s;
                    if (d.ok) begin
                        res[n[0]] = '{data: b, valid: 1'b1, run_last: 1'b0,
                                      msg_end: 1'b0, len: s.count};
                        n = n + 2'd1;
                    end
                end
                else if (b == BSLASH) begin
                    s.held = 1'b1;
                end
                else begin
                    s.stopped = 1'b1;
                end
            end
        end

        // A final byte always reports the length
        if (last && n == 2'd0) begin
            res[0] = '{data: NUL_CH, valid: 1'b0, run_last: 1'b0,
                       msg_end: 1'b0, len: s.count};
            n = 2'd1;
        end

        idx = n[1];
        if (n != 2'd0) begin
            res[idx].run_last = 1'b1;
            res[idx].msg_end  = last;
        end

        step.n    = n;
        step.r0   = res[0];
        step.r1   = res[1];
        step.next = last ? codec_state_t'('0) : s;
    end

endmodule

`default_nettype wire

// File: src/backslash_escape_codec.sv
// Top level of the backslash escape codec: input register, codec state,
// configuration registers and a four-word result queue. Depends on bec_pkg, bec_step.
//
// Usage:
//   Input channel in_valid/in_stall carries in_byte and in_last; a word is taken
//   at a clock edge with in_valid high and in_stall low. Output channel
//   out_valid/out_stall carries out_byte, byte_valid, run_last, message_end and
//   out_length. direction and out_limit are written through cfg_we, cfg_index
//   and cfg_data while the block is idle.
//   The input register holds a taken word until the step processes it and
//   writes its results into the queue, whose head word drives the output.
//   Throughput: one input word per cycle while out_stall is low and each word
//   gives at most one result; a word that expands to two results (encoded NUL
//   or backslash) fills the queue by one extra word, so a run of them is bound
//   by the single read port of the result queue.
//   The processing step waits while the queue holds more than two words.
//   Reset clears the codec state, the queue and the input register and sets
//   direction to encode and out_limit to 65535. While out_stall is high the
//   queue holds its head word, fills, and then in_stall rises.
`default_nettype none

module backslash_escape_codec (
    input  wire                 clk,
    input  wire                 rst_n,
    input  wire                 cfg_we,
    input  wire                 cfg_index,
    input  wire [15:0]          cfg_data,
    input  wire                 in_valid,
    output logic                in_stall,
    input  wire bec_pkg::byte_t in_byte,
    input  wire                 in_last,
    output logic                out_valid,
    input  wire                 out_stall,
    output bec_pkg::byte_t      out_byte,
    output logic                byte_valid,
    output logic                run_last,
    output logic                message_end,
    output logic [16:0]         out_length
);
    import bec_pkg::*;

    localparam int QDEPTH = 4;
    localparam int QAW    = $clog2(QDEPTH);

    // Configuration registers
    logic         dir_reg;
    logic [15:0]  lim_reg;

    // Input register
    logic         in_valid_reg;
    byte_t        in_byte_reg;
    logic         in_last_reg;

    // Codec state
    codec_state_t st_reg;
    step_t        step;

    // Result queue
    result_t          q_reg [QDEPTH];
    logic [QAW-1:0]   wr_ptr_reg;
    logic [QAW-1:0]   wr_ptr_next;
    logic [QAW-1:0]   rd_ptr_reg;
    logic [QAW-1:0]   rd_ptr_next;
    logic [QAW:0]     cnt_reg;
    logic [QAW:0]     cnt_next;
    logic [1:0]       push_n;
    logic             proc;
    logic             pop;
    result_t          head;

    // Configuration writes
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n) begin
            dir_reg <= DIR_ENCODE;
            lim_reg <= 16'hFFFF;
        end
        else if (cfg_we) begin
            case (cfg_index)
                CFG_DIRECTION: dir_reg <= cfg_data[0];
                CFG_OUT_LIMIT: lim_reg <= cfg_data;
                default:       dir_reg <= dir_reg;
            endcase
        end
    end

    // Handshake and queue control
    always_comb
    begin
        proc        = in_valid_reg && (cnt_reg <= (QAW+1)'(QDEPTH - 2));
        in_stall    = in_valid_reg && !proc;
        pop         = out_valid && !out_stall;
        push_n      = proc ? step.n : 2'd0;
        wr_ptr_next = wr_ptr_reg + QAW'(push_n);
        rd_ptr_next = rd_ptr_reg + QAW'(pop);
        cnt_next    = cnt_reg + (QAW+1)'(push_n) - (QAW+1)'(pop);
    end

    bec_step u_step (
        .st   (st_reg),
        .b    (in_byte_reg),
        .last (in_last_reg),
        .dir  (dir_reg),
        .lim  (lim_reg),
        .step (step)
    );

    // Control registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n) begin
            in_valid_reg <= 1'b0;
            st_reg       <= '0;
            wr_ptr_reg   <= '0;
            rd_ptr_reg   <= '0;
            cnt_reg      <= '0;
        end
        else begin
            in_valid_reg <= in_stall ? 1'b1 : in_valid;
            if (proc) begin
                st_reg <= step.next;
            end
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            cnt_reg    <= cnt_next;
        end
    end

    // Payload registers
    always_ff @(posedge clk)
    begin
        if (!in_stall) begin
            in_byte_reg <= in_byte;
            in_last_reg <= in_last;
        end
        if (proc && step.n != 2'd0) begin
            q_reg[wr_ptr_reg] <= step.r0;
        end
        if (proc && step.n == 2'd2) begin
            q_reg[wr_ptr_reg + QAW'(1)] <= step.r1;
        end
    end

    // Output side
    always_comb
    begin
        head        = q_reg[rd_ptr_reg];
        out_valid   = (cnt_reg != '0);
        out_byte    = head.data;
        byte_valid  = head.valid;
        run_last    = head.run_last;
        message_end = head.msg_end;
        out_length  = head.len;
    end

    // Checks
    a_queue_bound: assert property (@(posedge clk) disable iff (!rst_n)
        cnt_reg <= (QAW+1)'(QDEPTH))
        else $error("result queue overflow");

    a_end_is_last: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && message_end |-> run_last)
        else $error("message end without run last");

    a_empty_result: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !byte_valid |-> out_byte == NUL_CH && message_end)
        else $error("empty result that is not a message end");

    a_clear_after_msg: assert property (@(posedge clk) disable iff (!rst_n)
        proc && in_last_reg |=> st_reg == codec_state_t'('0))
        else $error("state not cleared after message");

endmodule

`default_nettype wire
